// ===== rtl/sparse_coordinate_entry_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sparse coordinate entry table
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COORDINATE_ENTRY_TABLE_UNIT_ASSERT_SVH
`define SPARSE_COORDINATE_ENTRY_TABLE_UNIT_ASSERT_SVH

// Consequent checked in the cycle after the antecedent
`define SCET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scet assertion failed: next-cycle check");

// Consequent checked in the same cycle as the antecedent
`define SCET_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scet assertion failed: same-cycle check");

`endif

// ===== rtl/scet_pkg.sv =====
// ----------------------------------------------------------------------------
// scet_pkg
// Types and constants shared by the sparse coordinate entry table.
// ----------------------------------------------------------------------------
package scet_pkg;

  localparam int MAX_SLOTS   = 64;
  localparam int MAX_DIM     = 4096;
  localparam int BASE_OFFSET = 0;

  localparam int DIM_W   = 13;
  localparam int VAL_W   = 32;
  localparam int SLOT_W  = 6;
  localparam int USE_W   = 7;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;

  // Cell index width and a compare width that holds every slot-like value
  localparam int CELL_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SCMP_W  = ((CELL_W + 1) > USE_W) ? (CELL_W + 1) : USE_W;

  // Width for the index range check
  localparam int DIM_CLOG = $clog2(MAX_DIM + 2);
  localparam int CHK_W    = ((DIM_CLOG > DIM_W) ? DIM_CLOG : DIM_W) + 1;

  localparam logic [DIM_W-1:0] ROW_COUNT_RST    = DIM_W'(4096);
  localparam logic [DIM_W-1:0] COLUMN_COUNT_RST = DIM_W'(4096);
  localparam logic [USE_W-1:0] SLOTS_IN_USE_RST = '0;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_GET  = 2'd1,
    REQ_SET  = 2'd2,
    REQ_ADD  = 2'd3
  } scet_req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_SAT       = 2'd3
  } scet_status_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_SLOTS_IN_USE = 2'd2
  } scet_cfg_e;

  typedef struct packed {
    scet_req_e                req_type;
    logic [DIM_W-1:0]         row_idx;
    logic [DIM_W-1:0]         col_idx;
    logic signed [VAL_W-1:0]  data_value;
    logic [SLOT_W-1:0]        slot_number;
  } scet_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  read_value;
    scet_status_e             status;
  } scet_out_t;

  // Request token that walks the cell chain
  typedef struct packed {
    logic                     active;
    logic                     skip;
    logic                     found;
    scet_req_e                req_type;
    logic [DIM_W-1:0]         row_idx;
    logic [DIM_W-1:0]         col_idx;
    logic signed [VAL_W-1:0]  data_value;
    logic [SLOT_W-1:0]        slot_number;
    logic signed [VAL_W-1:0]  read_value;
    scet_status_e             status;
  } scet_probe_t;

endpackage

// ===== rtl/scet_cell.sv =====
// ----------------------------------------------------------------------------
// scet_cell
// One slot of the table: holds row, column and value, applies the passing
// request token to its slot and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module scet_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [scet_pkg::CELL_W-1:0]   cell_index,
  input  logic [scet_pkg::USE_W-1:0]    slots_in_use,
  input  scet_pkg::scet_probe_t         probe_in,
  output scet_pkg::scet_probe_t         probe_out
);
  import scet_pkg::*;

  logic [DIM_W-1:0]        slot_row;
  logic [DIM_W-1:0]        slot_col;
  logic signed [VAL_W-1:0] slot_value;

  scet_probe_t             probe_next;
  logic                    work;
  logic                    searched;
  logic                    hit;
  logic                    load_here;
  logic                    claim;
  logic signed [VAL_W:0]   sum;
  logic signed [VAL_W-1:0] add_result;
  logic                    add_sat;
  logic                    write_en;
  logic signed [VAL_W-1:0] write_value;

  // Decode what this cell does with the token
  assign work      = probe_in.active && !probe_in.skip;
  assign searched  = SCMP_W'(cell_index) < SCMP_W'(slots_in_use);
  assign hit       = searched && (slot_row == probe_in.row_idx) &&
                     (slot_col == probe_in.col_idx);
  assign load_here = work && (probe_in.req_type == REQ_LOAD) &&
                     (SCMP_W'(probe_in.slot_number) == SCMP_W'(cell_index));
  assign claim     = work && hit && !probe_in.found &&
                     ((probe_in.req_type == REQ_SET) || (probe_in.req_type == REQ_ADD));

  // Saturating accumulate
  assign sum     = {slot_value[VAL_W-1], slot_value} +
                   {probe_in.data_value[VAL_W-1], probe_in.data_value};
  assign add_sat = sum[VAL_W] != sum[VAL_W-1];

  always_comb begin
    if (!add_sat) begin
      add_result = sum[VAL_W-1:0];
    end else if (sum[VAL_W]) begin
      add_result = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      add_result = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // Build the outgoing token
  always_comb begin
    probe_next = probe_in;
    if (work && hit && (probe_in.req_type == REQ_GET)) begin
      probe_next.read_value = slot_value;
    end
    if (claim) begin
      probe_next.found  = 1'b1;
      probe_next.status = ((probe_in.req_type == REQ_ADD) && add_sat) ? ST_SAT : ST_OK;
    end
  end

  // Select the slot update
  always_comb begin
    write_en    = load_here || claim;
    write_value = probe_in.data_value;
    if (claim && (probe_in.req_type == REQ_ADD)) begin
      write_value = add_result;
    end
  end

  // Update the slot as the token passes
  always_ff @(posedge clk) begin
    if (adv && write_en) begin
      slot_value <= write_value;
    end
    if (adv && load_here) begin
      slot_row <= probe_in.row_idx;
      slot_col <= probe_in.col_idx;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.active <= 1'b0;
    end else if (adv) begin
      probe_out <= probe_next;
    end
  end

endmodule

// ===== rtl/sparse_coordinate_entry_table_unit.sv =====
// Requests walk a 64-cell chain one at a time: the token moves one slot per
// cycle while no stalled result holds the chain, and the next request enters
// once it leaves the chain.
// A stalled result freezes the chain; a new request may wait behind it.
// Reset clears the chain and sets row_count and column_count to 4096 and
// slots_in_use to 0; slot contents are undefined until loaded.
// ----------------------------------------------------------------------------
// sparse_coordinate_entry_table_unit
// Coordinate-list sparse matrix: load, get, set and saturating add over a
// chain of slot cells.
// ----------------------------------------------------------------------------
module sparse_coordinate_entry_table_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  scet_pkg::scet_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output scet_pkg::scet_out_t          out_data,
  input  logic                         cfg_we,
  input  logic [scet_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [scet_pkg::CFG_W-1:0]   cfg_data
);
  import scet_pkg::*;

  function automatic logic index_ok(input logic [DIM_W-1:0] idx,
                                    input logic [DIM_W-1:0] count);
    logic [CHK_W-1:0] cnt_e;
    logic [CHK_W-1:0] lim;
    logic [CHK_W-1:0] idx_e;
    cnt_e = CHK_W'(count);
    idx_e = CHK_W'(idx);
    lim   = (cnt_e > CHK_W'(MAX_DIM)) ? CHK_W'(MAX_DIM) : cnt_e;
    return (idx_e >= CHK_W'(BASE_OFFSET)) && (idx_e < lim + CHK_W'(BASE_OFFSET));
  endfunction

  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] column_count;
  logic [USE_W-1:0] slots_in_use;

  scet_probe_t      probe [MAX_SLOTS+1];
  scet_probe_t      entry_next;
  logic             busy;
  logic             adv;
  logic             in_xfer;
  logic             range_bad;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RST;
      column_count <= COLUMN_COUNT_RST;
      slots_in_use <= SLOTS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT:    row_count    <= cfg_data[DIM_W-1:0];
        CFG_COLUMN_COUNT: column_count <= cfg_data[DIM_W-1:0];
        CFG_SLOTS_IN_USE: slots_in_use <= cfg_data[USE_W-1:0];
        default:          ;
      endcase
    end
  end

  // Chain moves unless a finished result is held at the output
  assign adv       = !(probe[MAX_SLOTS].active && out_stall);
  assign in_stall  = busy || !adv;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = probe[MAX_SLOTS].active;

  // Classify the request at entry
  always_comb begin
    if (in_data.req_type == REQ_LOAD) begin
      range_bad = SCMP_W'(in_data.slot_number) >= SCMP_W'(MAX_SLOTS);
    end else begin
      range_bad = !index_ok(in_data.row_idx, row_count) ||
                  !index_ok(in_data.col_idx, column_count);
    end
    entry_next.active      = in_xfer;
    entry_next.skip        = range_bad;
    entry_next.found       = 1'b0;
    entry_next.req_type    = in_data.req_type;
    entry_next.row_idx     = in_data.row_idx;
    entry_next.col_idx     = in_data.col_idx;
    entry_next.data_value  = in_data.data_value;
    entry_next.slot_number = in_data.slot_number;
    entry_next.read_value  = '0;
    if (range_bad) begin
      entry_next.status = ST_RANGE;
    end else if ((in_data.req_type == REQ_SET) || (in_data.req_type == REQ_ADD)) begin
      entry_next.status = ST_NOT_FOUND;
    end else begin
      entry_next.status = ST_OK;
    end
  end

  // Entry stage of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      probe[0].active <= 1'b0;
    end else if (adv) begin
      probe[0] <= entry_next;
    end
  end

  // Track a request inside the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_xfer) begin
      busy <= 1'b1;
    end else if (adv && probe[MAX_SLOTS-1].active) begin
      busy <= 1'b0;
    end
  end

  // Row of slot cells
  for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
    scet_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .adv          (adv),
      .cell_index   (CELL_W'(k)),
      .slots_in_use (slots_in_use),
      .probe_in     (probe[k]),
      .probe_out    (probe[k+1])
    );
  end

  // Result from the chain's last register
  assign out_data.read_value = probe[MAX_SLOTS].read_value;
  assign out_data.status     = probe[MAX_SLOTS].status;

endmodule

// ===== rtl/scet_checker.sv =====
// ----------------------------------------------------------------------------
// scet_checker
// Port-level checks for the sparse coordinate entry table, bound to the top.
// ----------------------------------------------------------------------------
`include "sparse_coordinate_entry_table_unit_assert.svh"

module scet_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input scet_pkg::scet_out_t  out_data
);
  import scet_pkg::*;

  // A held result keeps its value
  `SCET_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // One request at a time: the input closes right after a transfer
  `SCET_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)

  // A result is delivered once and the next needs a full chain walk
  `SCET_ASSERT_NEXT(a_single_result, out_valid && !out_stall, !out_valid)

  // Results with a status other than OK never carry a value
  `SCET_ASSERT_SAME(a_flag_zero, out_valid && (out_data.status != ST_OK),
                    out_data.read_value == '0)

endmodule

bind sparse_coordinate_entry_table_unit scet_checker u_scet_checker (.*);
